### rtl/wdd_pkg.sv
package wdd_pkg;

	// Default width of the millisecond timestamp.
	localparam int unsigned TIME_WIDTH_DEF = 32;

	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned DEBOUNCE_W  = 16;
	localparam int unsigned PERIOD_W    = 32;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_WET_WHEN_LOW        = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS         = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT_ENABLE    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT_PERIOD_MS = 2'd3;

	// Reset values of the configuration registers.
	localparam logic                  WET_WHEN_LOW_RST        = 1'b1;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RST         = 16'd50;
	localparam logic                  HEARTBEAT_ENABLE_RST    = 1'b0;
	localparam logic [PERIOD_W-1:0]   HEARTBEAT_PERIOD_MS_RST = 32'd60000;

	// Input command codes.
	localparam logic CMD_POLL = 1'b0;
	localparam logic CMD_INIT = 1'b1;

	typedef struct packed {
		logic                  wet_when_low;
		logic [DEBOUNCE_W-1:0] debounce_ms;
		logic                  heartbeat_enable;
		logic [PERIOD_W-1:0]   heartbeat_period_ms;
	} wdd_cfg_t;

	typedef struct packed {
		logic is_wet;
		logic rain_started;
		logic rain_stopped;
		logic heartbeat_due;
	} wdd_result_t;

endpackage

### rtl/wdd_in_if.sv
interface wdd_in_if #(
	parameter int unsigned TIME_WIDTH = wdd_pkg::TIME_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic                  pin_level;
	logic [TIME_WIDTH-1:0] now_ms;

	modport source (output valid, output cmd, output pin_level, output now_ms, input ready);
	modport sink (input valid, input cmd, input pin_level, input now_ms, output ready);
endinterface

### rtl/wdd_out_if.sv
interface wdd_out_if;
	logic valid;
	logic ready;
	logic is_wet;
	logic rain_started;
	logic rain_stopped;
	logic heartbeat_due;

	modport source (output valid, output is_wet, output rain_started,
		output rain_stopped, output heartbeat_due, input ready);
	modport sink (input valid, input is_wet, input rain_started,
		input rain_stopped, input heartbeat_due, output ready);
endinterface

### rtl/wet_dry_debounce_fsm_core.sv
// Channel  Direction  Word
// in_ch    sink       cmd, pin_level, now_ms[TIME_WIDTH-1:0]
// out_ch   source     is_wet, rain_started, rain_stopped, heartbeat_due
// cfg      write      cfg_wr_en, cfg_index[1:0], cfg_data[31:0]
//
// Each word goes through an input register and then a result register, one word per
// cycle sustained while the output is ready.
// The debounce state is updated as a word moves from the input to the result register.
// A stalled output holds its result; the input register still takes a word until it is full.
// Reset clears the debounce state, both timers and the configuration to defaults.
module wet_dry_debounce_fsm_core #(
	parameter int unsigned TIME_WIDTH = wdd_pkg::TIME_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [wdd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [wdd_pkg::CFG_DATA_W-1:0]    cfg_data,
	wdd_in_if.sink                            in_ch,
	wdd_out_if.source                         out_ch
);

	wdd_pkg::wdd_cfg_t    cfg_q;
	wdd_pkg::wdd_result_t result_s2;
	logic                  valid_s1, valid_s2;
	logic                  cmd_s1, pin_level_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  advance, in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wet_when_low        <= wdd_pkg::WET_WHEN_LOW_RST;
			cfg_q.debounce_ms         <= wdd_pkg::DEBOUNCE_MS_RST;
			cfg_q.heartbeat_enable    <= wdd_pkg::HEARTBEAT_ENABLE_RST;
			cfg_q.heartbeat_period_ms <= wdd_pkg::HEARTBEAT_PERIOD_MS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wdd_pkg::REG_WET_WHEN_LOW:
					cfg_q.wet_when_low <= cfg_data[0];
				wdd_pkg::REG_DEBOUNCE_MS:
					cfg_q.debounce_ms <= cfg_data[wdd_pkg::DEBOUNCE_W-1:0];
				wdd_pkg::REG_HEARTBEAT_ENABLE:
					cfg_q.heartbeat_enable <= cfg_data[0];
				wdd_pkg::REG_HEARTBEAT_PERIOD_MS:
					cfg_q.heartbeat_period_ms <= cfg_data[wdd_pkg::PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A word leaves the input register whenever the result register is free or draining.
	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_fire     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (!valid_s2 || out_ch.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1       <= in_ch.cmd;
			pin_level_s1 <= in_ch.pin_level;
			now_s1       <= in_ch.now_ms;
		end
	end

	wdd_step #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.advance      (advance),
		.cmd_s1       (cmd_s1),
		.pin_level_s1 (pin_level_s1),
		.now_s1       (now_s1),
		.result_s2    (result_s2)
	);

	assign out_ch.valid         = valid_s2;
	assign out_ch.is_wet        = result_s2.is_wet;
	assign out_ch.rain_started  = result_s2.rain_started;
	assign out_ch.rain_stopped  = result_s2.rain_stopped;
	assign out_ch.heartbeat_due = result_s2.heartbeat_due;

	// A start and a stop cannot complete on the same word.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.rain_started && result_s2.rain_stopped))
		else $error("rain started and stopped on one word");

	// A start leaves the state wet and a stop leaves it dry.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (result_s2.rain_started || result_s2.rain_stopped) |->
			result_s2.is_wet == result_s2.rain_started)
		else $error("transition flag disagrees with debounced state");

	// A word in the input register is never dropped while the result side stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ch.ready |=> valid_s1)
		else $error("input word lost during output stall");

endmodule

### rtl/wdd_step.sv
module wdd_step #(
	parameter int unsigned TIME_WIDTH = wdd_pkg::TIME_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wdd_pkg::wdd_cfg_t      cfg,
	input  logic                   advance,
	input  logic                   cmd_s1,
	input  logic                   pin_level_s1,
	input  logic [TIME_WIDTH-1:0]  now_s1,
	output wdd_pkg::wdd_result_t   result_s2
);

	// Compare width wide enough for both the elapsed time and the 32-bit period.
	localparam int unsigned CMP_W = (TIME_WIDTH > wdd_pkg::PERIOD_W) ?
		TIME_WIDTH : wdd_pkg::PERIOD_W;

	typedef enum logic [1:0] {
		PH_DRY_STABLE  = 2'd0,
		PH_CONFIRM_WET = 2'd1,
		PH_WET_STABLE  = 2'd2,
		PH_CONFIRM_DRY = 2'd3
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [TIME_WIDTH-1:0] window_start_q, window_start_d;
	logic [TIME_WIDTH-1:0] last_heartbeat_q, last_heartbeat_d;
	logic                  raw_wet;
	logic [TIME_WIDTH-1:0] win_elapsed, beat_elapsed;
	logic                  win_done, beat_done;
	logic                  started, stopped, beat;

	assign raw_wet      = cfg.wet_when_low ? ~pin_level_s1 : pin_level_s1;
	assign win_elapsed  = now_s1 - window_start_q;
	assign beat_elapsed = now_s1 - last_heartbeat_q;
	assign win_done     = CMP_W'(win_elapsed) >= CMP_W'(cfg.debounce_ms);
	assign beat_done    = CMP_W'(beat_elapsed) >= CMP_W'(cfg.heartbeat_period_ms);

	always_comb begin
		phase_d          = phase_q;
		window_start_d   = window_start_q;
		last_heartbeat_d = last_heartbeat_q;
		started          = 1'b0;
		stopped          = 1'b0;
		beat             = 1'b0;
		if (cmd_s1 == wdd_pkg::CMD_INIT) begin
			phase_d          = raw_wet ? PH_WET_STABLE : PH_DRY_STABLE;
			window_start_d   = now_s1;
			last_heartbeat_d = now_s1;
		end else begin
			case (phase_q)
				PH_DRY_STABLE: begin
					if (raw_wet) begin
						phase_d        = PH_CONFIRM_WET;
						window_start_d = now_s1;
					end
				end
				PH_CONFIRM_WET: begin
					if (!raw_wet) begin
						phase_d = PH_DRY_STABLE;
					end else if (win_done) begin
						phase_d = PH_WET_STABLE;
						started = 1'b1;
					end
				end
				PH_WET_STABLE: begin
					if (!raw_wet) begin
						phase_d        = PH_CONFIRM_DRY;
						window_start_d = now_s1;
					end
				end
				default: begin
					if (raw_wet) begin
						phase_d = PH_WET_STABLE;
					end else if (win_done) begin
						phase_d = PH_DRY_STABLE;
						stopped = 1'b1;
					end
				end
			endcase
			if (cfg.heartbeat_enable && beat_done) begin
				last_heartbeat_d = now_s1;
				beat             = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_DRY_STABLE;
			window_start_q   <= '0;
			last_heartbeat_q <= '0;
			result_s2        <= '0;
		end else if (advance) begin
			phase_q                 <= phase_d;
			window_start_q          <= window_start_d;
			last_heartbeat_q        <= last_heartbeat_d;
			result_s2.is_wet        <= (phase_d == PH_WET_STABLE) || (phase_d == PH_CONFIRM_DRY);
			result_s2.rain_started  <= started;
			result_s2.rain_stopped  <= stopped;
			result_s2.heartbeat_due <= beat;
		end
	end

	// A completed confirm-wet always lands in the wet stable phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && started |=> phase_q == PH_WET_STABLE)
		else $error("rain start did not reach wet stable");

	// A completed confirm-dry always lands in the dry stable phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && stopped |=> phase_q == PH_DRY_STABLE)
		else $error("rain stop did not reach dry stable");

	// The registered wet flag follows the phase it was taken from.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_s2.is_wet ==
			((phase_q == PH_WET_STABLE) || (phase_q == PH_CONFIRM_DRY)))
		else $error("is_wet disagrees with phase");

endmodule

### sim/tb_wet_dry_debounce_fsm_core.sv
`timescale 1ns / 1ps

module tb_wet_dry_debounce_fsm_core;

	typedef enum logic [1:0] {
		DRY_STABLE  = 2'd0,
		CONFIRM_WET = 2'd1,
		WET_STABLE  = 2'd2,
		CONFIRM_DRY = 2'd3
	} deb_phase_t;

	localparam int RANDOM_WORDS = 306;
	localparam int SHOWN_ERRORS = 10;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [wdd_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [wdd_pkg::CFG_DATA_W-1:0]  cfg_data;

	wdd_in_if #(.TIME_WIDTH(32)) in_ch ();
	wdd_out_if out_ch ();

	wet_dry_debounce_fsm_core #(.TIME_WIDTH(32)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Shadow copy of the debouncer and its settings.
	wdd_pkg::wdd_cfg_t shadow_cfg;
	deb_phase_t        shadow_phase;
	logic [31:0]       shadow_window;
	logic [31:0]       shadow_beat;

	wdd_pkg::wdd_result_t pending_results[$];
	int                   error_count;
	int                   send_idle_pct;
	int                   recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic log_failure(input string msg);
		if (error_count < SHOWN_ERRORS) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
		error_count++;
	endtask

	function automatic wdd_pkg::wdd_result_t predict_debounce(input logic cmd, input logic pin,
			input logic [31:0] now);
		wdd_pkg::wdd_result_t res;
		logic                 raw_wet;
		raw_wet = shadow_cfg.wet_when_low ? !pin : pin;
		res = '0;
		if (cmd == wdd_pkg::CMD_INIT) begin
			shadow_phase  = raw_wet ? WET_STABLE : DRY_STABLE;
			shadow_window = now;
			shadow_beat   = now;
		end else begin
			case (shadow_phase)
				DRY_STABLE: begin
					if (raw_wet) begin
						shadow_phase  = CONFIRM_WET;
						shadow_window = now;
					end
				end
				CONFIRM_WET: begin
					if (!raw_wet) begin
						shadow_phase = DRY_STABLE;
					end else if (now - shadow_window >= 32'(shadow_cfg.debounce_ms)) begin
						shadow_phase     = WET_STABLE;
						res.rain_started = 1'b1;
					end
				end
				WET_STABLE: begin
					if (!raw_wet) begin
						shadow_phase  = CONFIRM_DRY;
						shadow_window = now;
					end
				end
				default: begin
					if (raw_wet) begin
						shadow_phase = WET_STABLE;
					end else if (now - shadow_window >= 32'(shadow_cfg.debounce_ms)) begin
						shadow_phase     = DRY_STABLE;
						res.rain_stopped = 1'b1;
					end
				end
			endcase
			if (shadow_cfg.heartbeat_enable &&
					(now - shadow_beat >= shadow_cfg.heartbeat_period_ms)) begin
				shadow_beat       = now;
				res.heartbeat_due = 1'b1;
			end
		end
		res.is_wet = (shadow_phase == WET_STABLE) || (shadow_phase == CONFIRM_DRY);
		return res;
	endfunction

	// Presents one word, holds it until accepted and records its expected result.
	task automatic send_sample(input logic cmd, input logic pin, input logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.cmd       <= cmd;
		in_ch.pin_level <= pin;
		in_ch.now_ms    <= now;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		pending_results.push_back(predict_debounce(cmd, pin, now));
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		// Let the pipeline settle past its two stages.
		repeat (4) @(posedge clk);
	endtask

	// Writes all four registers on consecutive cycles; upper data bits are junk, except for the period, which uses all 32.
	task automatic apply_settings(input logic wwl, input logic [15:0] db, input logic hb_en,
			input logic [31:0] period);
		cfg_wr_en <= 1'b1;
		cfg_index <= wdd_pkg::REG_WET_WHEN_LOW;
		cfg_data  <= ($urandom & 32'hFFFF_FFFE) | 32'(wwl);
		@(posedge clk);
		cfg_index <= wdd_pkg::REG_DEBOUNCE_MS;
		cfg_data  <= ($urandom & 32'hFFFF_0000) | 32'(db);
		@(posedge clk);
		cfg_index <= wdd_pkg::REG_HEARTBEAT_ENABLE;
		cfg_data  <= ($urandom & 32'hFFFF_FFFE) | 32'(hb_en);
		@(posedge clk);
		cfg_index <= wdd_pkg::REG_HEARTBEAT_PERIOD_MS;
		cfg_data  <= period;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_cfg.wet_when_low        = wwl;
		shadow_cfg.debounce_ms         = db;
		shadow_cfg.heartbeat_enable    = hb_en;
		shadow_cfg.heartbeat_period_ms = period;
	endtask

	task automatic test_default_settings();
		send_sample(wdd_pkg::CMD_INIT, 1'b1, 32'd0);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'd10);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'd59);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'd60);
		send_sample(wdd_pkg::CMD_POLL, 1'b1, 32'd70);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'd80);
		send_sample(wdd_pkg::CMD_POLL, 1'b1, 32'd100);
		send_sample(wdd_pkg::CMD_POLL, 1'b1, 32'd150);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'd160);
		send_sample(wdd_pkg::CMD_POLL, 1'b1, 32'd170);
		send_sample(wdd_pkg::CMD_INIT, 1'b0, 32'hFFFF_FFFF);
		// Confirm window that spans the wrap of the timestamp.
		send_sample(wdd_pkg::CMD_INIT, 1'b1, 32'hFFFF_FFF0);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'hFFFF_FFF8);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'h0000_0030);
		wait_drained();
	endtask

	task automatic test_zero_window();
		apply_settings(1'b0, 16'd0, 1'b1, 32'd0);
		send_sample(wdd_pkg::CMD_INIT, 1'b0, 32'd0);
		send_sample(wdd_pkg::CMD_POLL, 1'b1, 32'd0);
		send_sample(wdd_pkg::CMD_POLL, 1'b1, 32'd0);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'd5);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'd5);
		wait_drained();
	endtask

	task automatic test_max_window();
		apply_settings(1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		send_sample(wdd_pkg::CMD_INIT, 1'b1, 32'h1234_5678);
		send_sample(wdd_pkg::CMD_POLL, 1'b1, 32'h1234_5677);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'h8000_0000);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'h8000_FFFE);
		send_sample(wdd_pkg::CMD_POLL, 1'b0, 32'h8000_FFFF);
		send_sample(wdd_pkg::CMD_POLL, 1'b1, 32'hAAAA_AAAA);
		wait_drained();
	endtask

	// Mostly runs of steady pin levels with time advancing on the scale of the
	// window, mixed with timestamp jumps and initialize words.
	task automatic test_random_samples(input int idle_pct, input int stall_pct,
			input logic wwl, input logic [15:0] db, input logic hb_en, input logic [31:0] period);
		logic [31:0] clock_ms;
		logic        pin;
		int          roll;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		apply_settings(wwl, db, hb_en, period);
		clock_ms = $urandom;
		pin      = $urandom_range(1);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			roll = $urandom_range(99);
			if ($urandom_range(9) == 0) begin
				pin = !pin;
			end
			if (roll < 3) begin
				clock_ms = $urandom;
			end else if (roll >= 5) begin
				clock_ms = clock_ms + $urandom_range(0, (int'(db) >> 2) + 4);
			end
			send_sample((roll == 3 || roll == 4) ? wdd_pkg::CMD_INIT : wdd_pkg::CMD_POLL,
				pin, clock_ms);
		end
		wait_drained();
	endtask

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		wdd_pkg::wdd_result_t got;
		wdd_pkg::wdd_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.is_wet, out_ch.rain_started, out_ch.rain_stopped,
				out_ch.heartbeat_due};
			if (pending_results.size() == 0) begin
				log_failure($sformatf("unexpected word %b", got));
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					log_failure($sformatf(
						"wet/started/stopped/heartbeat expected %b got %b", want, got));
				end
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_index       <= wdd_pkg::REG_WET_WHEN_LOW;
		cfg_data        <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.cmd       <= wdd_pkg::CMD_POLL;
		in_ch.pin_level <= 1'b0;
		in_ch.now_ms    <= '0;
		error_count     = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		shadow_cfg.wet_when_low        = wdd_pkg::WET_WHEN_LOW_RST;
		shadow_cfg.debounce_ms         = wdd_pkg::DEBOUNCE_MS_RST;
		shadow_cfg.heartbeat_enable    = wdd_pkg::HEARTBEAT_ENABLE_RST;
		shadow_cfg.heartbeat_period_ms = wdd_pkg::HEARTBEAT_PERIOD_MS_RST;
		shadow_phase  = DRY_STABLE;
		shadow_window = '0;
		shadow_beat   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_settings();
		test_zero_window();
		test_max_window();
		test_random_samples(0, 0, 1'($urandom), 16'($urandom_range(5, 100)), 1'b1,
			32'($urandom_range(50, 2000)));
		test_random_samples(50, 0, 1'b1, 16'd0, 1'b1, 32'd0);
		test_random_samples(0, 50, 1'b0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		test_random_samples(32, 32, 1'($urandom), 16'($urandom_range(1, 300)), 1'b0,
			$urandom);

		if (pending_results.size() != 0) begin
			log_failure($sformatf("%0d words never arrived", pending_results.size()));
		end
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
